FILE: hdl/bgai_pkg.sv
// Shared widths, codes, table lookups and status decode for the battery gauge.
package bgai_pkg;

    localparam int SAMPLE_W    = 12;
    localparam int RATIO_W     = 12;
    localparam int FRAC_BITS   = 8;
    localparam int MV_W        = 16;
    localparam int PCT_W       = 7;
    localparam int STATUS_W    = 2;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 12;

    localparam int SAMPLES_PER_READING_DEF = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_DIVIDER_RATIO = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CHARGE_PIN    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_STANDBY_PIN   = 2'd2;

    localparam logic [RATIO_W-1:0] RATIO_RESET = 12'd512;

    localparam logic [STATUS_W-1:0] STATUS_UNKNOWN     = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_CHARGING    = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL        = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_DISCHARGING = 2'd3;

    localparam int VOLT_MIN_MV  = 3100;
    localparam int VOLT_MAX_MV  = 4200;
    localparam int VOLT_STEP_MV = 100;
    localparam int SEGMENTS     = 11;
    localparam int SEG_W        = 4;
    localparam int DIFF_W       = 7;
    localparam int PCT_FULL     = 100;

    localparam int RECIP_W     = 6;
    localparam int RECIP_100   = 41;
    localparam int RECIP_SHIFT = 12;

    typedef struct packed {
        logic charge_pin;
        logic standby_pin;
    } pin_cfg_t;

    // Percent at each table point, counted upwards from the lowest voltage.
    function automatic logic [PCT_W-1:0] pct_point(input logic [SEG_W-1:0] k);
        logic [PCT_W-1:0] p;
        begin
            unique case (k)
                4'd0:    p = 7'd0;
                4'd1:    p = 7'd5;
                4'd2:    p = 7'd10;
                4'd3:    p = 7'd20;
                4'd4:    p = 7'd30;
                4'd5:    p = 7'd40;
                4'd6:    p = 7'd50;
                4'd7:    p = 7'd60;
                4'd8:    p = 7'd70;
                4'd9:    p = 7'd80;
                4'd10:   p = 7'd90;
                default: p = 7'd100;
            endcase
            return p;
        end
    endfunction

    function automatic logic [STATUS_W-1:0] decode_status(input pin_cfg_t pins,
                                                          input logic chg,
                                                          input logic stby);
        logic [STATUS_W-1:0] s;
        begin
            priority if (!pins.charge_pin && !pins.standby_pin)
                s = STATUS_UNKNOWN;
            else if (pins.charge_pin && chg)
                s = STATUS_CHARGING;
            else if (pins.standby_pin && stby)
                s = STATUS_FULL;
            else
                s = STATUS_DISCHARGING;
            return s;
        end
    endfunction

endpackage

FILE: hdl/bgai_serial_mul.sv
// Shift-and-add multiplier taking one multiplier bit per cycle, most significant first.
module bgai_serial_mul #(
    parameter int MCAND_W = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    input  logic [MCAND_W-1:0]                    multiplicand,
    input  logic [bgai_pkg::RATIO_W-1:0]          multiplier,
    output logic                                  done,
    output logic [MCAND_W+bgai_pkg::RATIO_W-1:0]  product
);
    import bgai_pkg::*;

    localparam int PROD_W = MCAND_W + RATIO_W;
    localparam int CNT_W  = $clog2(RATIO_W + 1);

    logic [PROD_W-1:0]  acc_reg, acc_next;
    logic [MCAND_W-1:0] mcand_reg, mcand_next;
    logic [RATIO_W-1:0] mplr_reg, mplr_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               run_reg, run_next;
    logic               done_reg, done_next;

    always_comb
    begin
        acc_next   = acc_reg;
        mcand_next = mcand_reg;
        mplr_next  = mplr_reg;
        cnt_next   = cnt_reg;
        run_next   = run_reg;
        done_next  = 1'b0;
        if (start)
        begin
            acc_next   = '0;
            mcand_next = multiplicand;
            mplr_next  = multiplier;
            cnt_next   = CNT_W'(RATIO_W);
            run_next   = 1'b1;
        end
        else if (run_reg)
        begin
            acc_next  = {acc_reg[PROD_W-2:0], 1'b0}
                        + (mplr_reg[RATIO_W-1] ? PROD_W'(mcand_reg) : '0);
            mplr_next = {mplr_reg[RATIO_W-2:0], 1'b0};
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg   <= acc_next;
        mcand_reg <= mcand_next;
        mplr_reg  <= mplr_next;
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

FILE: hdl/bgai_serial_div.sv
// Restoring divider by a fixed divisor, one quotient bit per cycle.
module bgai_serial_div #(
    parameter int NUM_W   = 28,
    parameter int DIVISOR = 4096
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] dividend,
    output logic             done,
    output logic [NUM_W-1:0] quotient
);
    localparam int REM_W = $clog2(DIVISOR) + 1;
    localparam int CNT_W = $clog2(NUM_W + 1);
    localparam logic [REM_W-1:0] DIV_C = REM_W'(DIVISOR);

    logic [NUM_W-1:0] num_reg, num_next;
    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [REM_W-1:0] rem_reg, rem_next;
    logic [REM_W-1:0] rem_shift;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             run_reg, run_next;
    logic             done_reg, done_next;

    always_comb
    begin
        num_next  = num_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        rem_shift = {rem_reg[REM_W-2:0], num_reg[NUM_W-1]};
        if (start)
        begin
            num_next = dividend;
            quo_next = '0;
            rem_next = '0;
            cnt_next = CNT_W'(NUM_W);
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            num_next = {num_reg[NUM_W-2:0], 1'b0};
            if (rem_shift >= DIV_C)
            begin
                rem_next = rem_shift - DIV_C;
                quo_next = {quo_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_shift;
                quo_next = {quo_reg[NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

FILE: hdl/bgai_percent.sv
// Two-stage piecewise-linear lookup from battery millivolts to charge percent.
module bgai_percent (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [bgai_pkg::MV_W-1:0]   mv,
    output logic                        done,
    output logic [bgai_pkg::PCT_W-1:0]  percent
);
    import bgai_pkg::*;

    localparam logic [1:0] SEL_EMPTY  = 2'd0;
    localparam logic [1:0] SEL_FULL   = 2'd1;
    localparam logic [1:0] SEL_INTERP = 2'd2;

    localparam int PROD_W   = DIFF_W + PCT_W;
    localparam int SCALED_W = PROD_W + RECIP_W;

    logic [1:0]          sel_reg, sel_next;
    logic [SEG_W-1:0]    seg_reg, seg_next;
    logic [DIFF_W-1:0]   diff_reg, diff_next;
    logic                s1_reg;
    logic                done_reg;
    logic [PCT_W-1:0]    pct_reg, pct_next;
    logic [PCT_W-1:0]    span;
    logic [PROD_W-1:0]   prod;
    logic [SCALED_W-1:0] scaled;

    always_comb
    begin
        seg_next  = '0;
        diff_next = '0;
        for (int k = 0; k < SEGMENTS; k++)
        begin
            if (mv > MV_W'(VOLT_MIN_MV + k * VOLT_STEP_MV))
            begin
                seg_next  = SEG_W'(k);
                diff_next = DIFF_W'(mv - MV_W'(VOLT_MIN_MV + k * VOLT_STEP_MV));
            end
        end
        priority if (mv >= MV_W'(VOLT_MAX_MV))
            sel_next = SEL_FULL;
        else if (mv <= MV_W'(VOLT_MIN_MV))
            sel_next = SEL_EMPTY;
        else
            sel_next = SEL_INTERP;
    end

    always_comb
    begin
        span   = pct_point(seg_reg + 1'b1) - pct_point(seg_reg);
        prod   = PROD_W'(diff_reg) * PROD_W'(span);
        scaled = SCALED_W'(prod) * SCALED_W'(RECIP_100);
        unique case (sel_reg)
            SEL_FULL:   pct_next = PCT_W'(PCT_FULL);
            SEL_INTERP: pct_next = pct_point(seg_reg) + PCT_W'(scaled >> RECIP_SHIFT);
            default:    pct_next = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            s1_reg   <= start;
            done_reg <= s1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            sel_reg  <= sel_next;
            seg_reg  <= seg_next;
            diff_reg <= diff_next;
        end
        if (s1_reg)
        begin
            pct_reg <= pct_next;
        end
    end

    assign done    = done_reg;
    assign percent = pct_reg;

endmodule

FILE: hdl/battery_gauge_average_interpolate_unit.sv
// Top level of the battery gauge: block averaging, voltage restore, percent and status.
//
//   Channel | Direction | Handshake            | Payload
//   in      | input     | in_valid / in_ready   | sample_mv, charge_active, standby_active
//   cfg     | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//   out     | output    | out_valid / out_ready | battery_mv, charge_percent, charge_status
//
// A request that does not close a block is added to the sum. The closing request starts
// a shift-and-add multiply by the divider ratio, then a restoring division over the
// product bits (28 at the default block length), then the table lookup, each unit
// started when the one before it is done.
// The input waits until the reading is loaded into the output register, which may still
// hold an earlier reading; out_ready low holds it there.
// Reset clears the sum, the count and out_valid, and sets the state, ratio and pins to their defaults.
module battery_gauge_average_interpolate_unit #(
    parameter int SAMPLES_PER_READING = bgai_pkg::SAMPLES_PER_READING_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [bgai_pkg::SAMPLE_W-1:0]      sample_mv,
    input  logic                               charge_active,
    input  logic                               standby_active,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [bgai_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [bgai_pkg::CFG_DATA_W-1:0]    cfg_data,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [bgai_pkg::MV_W-1:0]          battery_mv,
    output logic [bgai_pkg::PCT_W-1:0]         charge_percent,
    output logic [bgai_pkg::STATUS_W-1:0]      charge_status
);
    import bgai_pkg::*;

    localparam int SUM_W   = SAMPLE_W + $clog2(SAMPLES_PER_READING);
    localparam int PROD_W  = SUM_W + RATIO_W;
    localparam int CNT_W   = (SAMPLES_PER_READING > 1) ? $clog2(SAMPLES_PER_READING) : 1;
    localparam int DIVISOR = SAMPLES_PER_READING * (1 << FRAC_BITS);
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(SAMPLES_PER_READING - 1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_DIV  = 3'd2;
    localparam logic [2:0] ST_PCT  = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [2:0]          state_reg, state_next;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [SUM_W-1:0]    sum_add;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [RATIO_W-1:0]  ratio_reg, ratio_next;
    pin_cfg_t            pins_reg, pins_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [MV_W-1:0]     mv_reg, mv_next;
    logic                out_valid_reg, out_valid_next;
    logic [MV_W-1:0]     out_mv_reg, out_mv_next;
    logic [PCT_W-1:0]    out_pct_reg, out_pct_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;

    logic                in_accept;
    logic                last_sample;
    logic                mul_start;
    logic                mul_done;
    logic [PROD_W-1:0]   product;
    logic                div_start;
    logic                div_done;
    logic [PROD_W-1:0]   quotient;
    logic [MV_W-1:0]     mv_sat;
    logic                pct_start;
    logic                pct_done;
    logic [PCT_W-1:0]    pct_value;
    logic                out_load;

    assign in_ready    = (state_reg == ST_IDLE);
    assign cfg_ready   = 1'b1;
    assign in_accept   = in_valid && in_ready;
    assign last_sample = (count_reg == LAST_CNT);
    assign sum_add     = sum_reg + SUM_W'(sample_mv);
    assign mul_start   = in_accept && last_sample;
    assign div_start   = (state_reg == ST_MUL) && mul_done;
    assign mv_sat      = (|quotient[PROD_W-1:MV_W]) ? '1 : quotient[MV_W-1:0];
    assign pct_start   = (state_reg == ST_DIV) && div_done;
    assign out_load    = (state_reg == ST_OUT) && (!out_valid_reg || out_ready);

    bgai_serial_mul #(
        .MCAND_W (SUM_W)
    ) u_mul (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (mul_start),
        .multiplicand (sum_add),
        .multiplier   (ratio_reg),
        .done         (mul_done),
        .product      (product)
    );

    bgai_serial_div #(
        .NUM_W   (PROD_W),
        .DIVISOR (DIVISOR)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (product),
        .done     (div_done),
        .quotient (quotient)
    );

    bgai_percent u_pct (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (pct_start),
        .mv      (mv_sat),
        .done    (pct_done),
        .percent (pct_value)
    );

    always_comb
    begin
        ratio_next = ratio_reg;
        pins_next  = pins_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_DIVIDER_RATIO: ratio_next = cfg_data[RATIO_W-1:0];
                CFG_CHARGE_PIN:    pins_next.charge_pin = cfg_data[0];
                CFG_STANDBY_PIN:   pins_next.standby_pin = cfg_data[0];
                default:           ratio_next = ratio_reg;
            endcase
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        sum_next    = sum_reg;
        count_next  = count_reg;
        status_next = status_reg;
        mv_next     = mv_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (last_sample)
                    begin
                        sum_next    = '0;
                        count_next  = '0;
                        status_next = decode_status(pins_reg, charge_active, standby_active);
                        state_next  = ST_MUL;
                    end
                    else
                    begin
                        sum_next   = sum_add;
                        count_next = count_reg + 1'b1;
                    end
                end
            end
            ST_MUL:
            begin
                if (mul_done)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    mv_next    = mv_sat;
                    state_next = ST_PCT;
                end
            end
            ST_PCT:
            begin
                if (pct_done)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_mv_next     = out_mv_reg;
        out_pct_next    = out_pct_reg;
        out_status_next = out_status_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (out_load)
        begin
            out_valid_next  = 1'b1;
            out_mv_next     = mv_reg;
            out_pct_next    = pct_value;
            out_status_next = status_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            sum_reg       <= '0;
            count_reg     <= '0;
            ratio_reg     <= RATIO_RESET;
            pins_reg      <= '{charge_pin: 1'b1, standby_pin: 1'b1};
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sum_reg       <= sum_next;
            count_reg     <= count_next;
            ratio_reg     <= ratio_next;
            pins_reg      <= pins_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg     <= status_next;
        mv_reg         <= mv_next;
        out_mv_reg     <= out_mv_next;
        out_pct_reg    <= out_pct_next;
        out_status_reg <= out_status_next;
    end

    assign out_valid      = out_valid_reg;
    assign battery_mv     = out_mv_reg;
    assign charge_percent = out_pct_reg;
    assign charge_status  = out_status_reg;

endmodule

FILE: hdl/bgai_checker.sv
// Port-level checks on the battery gauge, attached to the top level by a bind.
module bgai_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              out_valid,
    input logic                              out_ready,
    input logic [bgai_pkg::MV_W-1:0]         battery_mv,
    input logic [bgai_pkg::PCT_W-1:0]        charge_percent
);
    import bgai_pkg::*;

    // A pending reading is held until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(battery_mv)
                                    && $stable(charge_percent))
        else $error("output request changed while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> charge_percent <= PCT_W'(PCT_FULL))
        else $error("charge percent above full scale");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && battery_mv >= MV_W'(VOLT_MAX_MV) |-> charge_percent == PCT_W'(PCT_FULL))
        else $error("full voltage did not give full charge");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && battery_mv <= MV_W'(VOLT_MIN_MV) |-> charge_percent == '0)
        else $error("empty voltage did not give zero charge");

    // Percent never falls as voltage rises between two readings.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready ##1 out_valid && $past(battery_mv) <= battery_mv
            |-> $past(charge_percent, 1) <= charge_percent)
        else $error("charge percent not monotonic in voltage");

endmodule

bind battery_gauge_average_interpolate_unit bgai_checker u_bgai_checker (.*);
